// File: src/ttp_pkg.sv
// ----------------------------------------------------------------------------
// ttp_pkg: shared types and constants
// Widths, register codes, segment codes and pipeline latency for the
// trapezoid pressure profile.
// ----------------------------------------------------------------------------
package ttp_pkg;

  localparam int TIME_BITS       = 32;
  localparam int PRESSURE_BITS   = 16;
  localparam int RATIO_FRAC_BITS = 16;
  localparam int CYCLE_BITS      = 16;

  localparam int MAG_BITS  = TIME_BITS - 1;
  localparam int LEN_BITS  = CYCLE_BITS + RATIO_FRAC_BITS;
  localparam int U_BITS    = LEN_BITS + 1;
  localparam int PROD_BITS = PRESSURE_BITS + LEN_BITS;

  localparam int CFG_DATA_A    = (CYCLE_BITS > PRESSURE_BITS) ? CYCLE_BITS : PRESSURE_BITS;
  localparam int CFG_DATA_BITS = (CFG_DATA_A > RATIO_FRAC_BITS) ? CFG_DATA_A : RATIO_FRAC_BITS;
  localparam int CFG_IDX_BITS  = 2;

  // accept edge to the edge at which the result is sampled
  localparam int LAT_CYCLES = MAG_BITS + PRESSURE_BITS + 7;

  localparam logic [CFG_IDX_BITS-1:0] CFG_CYCLE_TIME   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INHALE_RATIO = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_PRESSURE = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_PRESSURE = 2'd3;

  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HOLD_HI,
    SEG_FALL,
    SEG_HOLD_LO
  } seg_t;

  typedef struct packed {
    logic [CYCLE_BITS-1:0]      cycle_time;
    logic [RATIO_FRAC_BITS-1:0] inhale_ratio;
    logic [PRESSURE_BITS-1:0]   min_pressure;
    logic [PRESSURE_BITS-1:0]   max_pressure;
  } cfg_t;

  // classified time word: sign and magnitude (~t for negative t)
  typedef struct packed {
    logic                neg;
    logic [MAG_BITS-1:0] mag;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: src/ttp_front.sv
// ----------------------------------------------------------------------------
// ttp_front: input front end
// Registers an accepted time word and splits it into sign and magnitude.
// ----------------------------------------------------------------------------
module ttp_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               accept,
  input  logic signed [ttp_pkg::TIME_BITS-1:0] sample_time,
  output logic                               vld,
  output ttp_pkg::item_t                     item
);

  logic           vld_r, vld_nxt;
  ttp_pkg::item_t item_r, item_nxt;

  always_comb begin
    vld_nxt      = accept;
    item_nxt.neg = sample_time[ttp_pkg::TIME_BITS-1];
    // negative: -(t+1) = ~t, which stays in range
    item_nxt.mag = item_nxt.neg ? ~sample_time[ttp_pkg::MAG_BITS-1:0]
                                :  sample_time[ttp_pkg::MAG_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign vld  = vld_r;
  assign item = item_r;

endmodule

// File: src/ttp_queue.sv
// ----------------------------------------------------------------------------
// ttp_queue: two-word queue between front and back
// Small FIFO; the back end pops whenever a word is present.
// ----------------------------------------------------------------------------
module ttp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ttp_pkg::item_t   push_item,
  input  logic             pop,
  output ttp_pkg::item_t   pop_item,
  output ttp_pkg::q_stat_t stat
);

  ttp_pkg::item_t mem [0:1];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  always_comb begin
    do_push    = push && (cnt_r != 2'd2);
    do_pop     = pop && (cnt_r != 2'd0);
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  assign pop_item   = mem[rd_ptr_r];
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

endmodule

// File: src/ttp_back.sv
// ----------------------------------------------------------------------------
// ttp_back: evaluation pipeline
// Bit-per-stage modulo by cycle time, segment select, ramp multiply and a
// bit-per-stage divide for the ramp value.
// ----------------------------------------------------------------------------
module ttp_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_vld,
  input  ttp_pkg::item_t                    in_item,
  input  ttp_pkg::cfg_t                     cfg,
  output logic                              out_vld,
  output logic [ttp_pkg::PRESSURE_BITS-1:0] out_p
);

  localparam int MB = ttp_pkg::MAG_BITS;
  localparam int CB = ttp_pkg::CYCLE_BITS;
  localparam int PB = ttp_pkg::PRESSURE_BITS;
  localparam int RB = ttp_pkg::RATIO_FRAC_BITS;
  localparam int LB = ttp_pkg::LEN_BITS;
  localparam int UB = ttp_pkg::U_BITS;
  localparam int XB = ttp_pkg::PROD_BITS;

  // ---- modulo stages ----
  logic          m_vld_r [0:MB];
  logic          m_neg_r [0:MB];
  logic [MB-1:0] m_mag_r [0:MB];
  logic [CB-1:0] m_rem_r [0:MB];
  logic [CB:0]   m_trial [0:MB-1];
  logic [CB-1:0] m_rem_nxt [0:MB-1];

  always_comb begin
    for (int k = 0; k < MB; k++) begin
      m_trial[k] = {m_rem_r[k], m_mag_r[k][MB-1]};
      if (m_trial[k] >= {1'b0, cfg.cycle_time}) begin
        m_rem_nxt[k] = CB'(m_trial[k] - {1'b0, cfg.cycle_time});
      end else begin
        m_rem_nxt[k] = m_trial[k][CB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= MB; k++) begin
        m_vld_r[k] <= 1'b0;
      end
    end else begin
      m_vld_r[0] <= in_vld;
      for (int k = 0; k < MB; k++) begin
        m_vld_r[k+1] <= m_vld_r[k];
      end
    end
    m_neg_r[0] <= in_item.neg;
    m_mag_r[0] <= in_item.mag;
    m_rem_r[0] <= '0;
    for (int k = 0; k < MB; k++) begin
      m_neg_r[k+1] <= m_neg_r[k];
      m_mag_r[k+1] <= {m_mag_r[k][MB-2:0], 1'b0};
      m_rem_r[k+1] <= m_rem_nxt[k];
    end
  end

  // ---- stage A: wrapped time and inhale boundary ----
  logic          a_vld_r;
  logic [UB-1:0] a_u_r, a_u_nxt;
  logic [LB-1:0] a_t0_r, a_t0_nxt;
  logic [CB-1:0] tw;

  always_comb begin
    if (cfg.cycle_time == '0) begin
      tw = '0;
    end else if (m_neg_r[MB]) begin
      tw = cfg.cycle_time - CB'(1) - m_rem_r[MB];
    end else begin
      tw = m_rem_r[MB];
    end
    a_u_nxt  = {tw, {(RB+1){1'b0}}};
    a_t0_nxt = LB'(cfg.inhale_ratio) * LB'(cfg.cycle_time);
  end

  // ---- stage B: segment select ----
  logic            b_vld_r;
  logic [PB-1:0]   b_from_r, b_from_nxt;
  logic [PB-1:0]   b_d_r, b_d_nxt;
  logic            b_up_r, b_up_nxt;
  logic [LB-1:0]   b_x_r, b_x_nxt;
  logic [LB-1:0]   b_len_r, b_len_nxt;
  ttp_pkg::seg_t   seg;
  logic [UB-1:0]   t1, t2;
  logic [PB-1:0]   to_p;

  always_comb begin
    t1 = {a_t0_r, 1'b0};
    t2 = UB'({cfg.cycle_time, {RB{1'b0}}}) + UB'(a_t0_r);
    if (a_u_r < UB'(a_t0_r))  seg = ttp_pkg::SEG_RISE;
    else if (a_u_r < t1)      seg = ttp_pkg::SEG_HOLD_HI;
    else if (a_u_r < t2)      seg = ttp_pkg::SEG_FALL;
    else                      seg = ttp_pkg::SEG_HOLD_LO;
    b_from_nxt = cfg.min_pressure;
    to_p       = cfg.min_pressure;
    b_x_nxt    = '0;
    b_len_nxt  = LB'(1);
    case (seg)
      ttp_pkg::SEG_RISE: begin
        b_from_nxt = cfg.min_pressure;
        to_p       = cfg.max_pressure;
        b_x_nxt    = a_u_r[LB-1:0];
        b_len_nxt  = a_t0_r;
      end
      ttp_pkg::SEG_HOLD_HI: begin
        b_from_nxt = cfg.max_pressure;
        to_p       = cfg.max_pressure;
      end
      ttp_pkg::SEG_FALL: begin
        b_from_nxt = cfg.max_pressure;
        to_p       = cfg.min_pressure;
        b_x_nxt    = LB'(a_u_r - t1);
        b_len_nxt  = LB'({cfg.cycle_time, {RB{1'b0}}}) - a_t0_r;
      end
      default: begin
        b_from_nxt = cfg.min_pressure;
        to_p       = cfg.min_pressure;
      end
    endcase
    b_up_nxt = (to_p >= b_from_nxt);
    b_d_nxt  = b_up_nxt ? (to_p - b_from_nxt) : (b_from_nxt - to_p);
  end

  // ---- divide stages: floor(d*x/len), stage 0 holds the product ----
  logic          q_vld_r  [0:PB];
  logic [PB-1:0] q_from_r [0:PB];
  logic          q_up_r   [0:PB];
  logic [LB-1:0] q_len_r  [0:PB];
  logic [LB-1:0] q_rem_r  [0:PB];
  logic [PB-1:0] q_low_r  [0:PB];
  logic [PB-1:0] q_quo_r  [0:PB];
  logic [LB:0]   q_trial  [0:PB-1];
  logic          q_bit    [0:PB-1];
  logic [XB-1:0] prod;

  always_comb begin
    prod = XB'(b_d_r) * XB'(b_x_r);
    for (int k = 0; k < PB; k++) begin
      q_trial[k] = {q_rem_r[k], q_low_r[k][PB-1]};
      q_bit[k]   = (q_trial[k] >= {1'b0, q_len_r[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      for (int k = 0; k <= PB; k++) begin
        q_vld_r[k] <= 1'b0;
      end
    end else begin
      a_vld_r    <= m_vld_r[MB];
      b_vld_r    <= a_vld_r;
      q_vld_r[0] <= b_vld_r;
      for (int k = 0; k < PB; k++) begin
        q_vld_r[k+1] <= q_vld_r[k];
      end
    end
    a_u_r    <= a_u_nxt;
    a_t0_r   <= a_t0_nxt;
    b_from_r <= b_from_nxt;
    b_d_r    <= b_d_nxt;
    b_up_r   <= b_up_nxt;
    b_x_r    <= b_x_nxt;
    b_len_r  <= b_len_nxt;
    q_from_r[0] <= b_from_r;
    q_up_r[0]   <= b_up_r;
    q_len_r[0]  <= b_len_r;
    q_rem_r[0]  <= prod[XB-1:PB];
    q_low_r[0]  <= prod[PB-1:0];
    q_quo_r[0]  <= '0;
    for (int k = 0; k < PB; k++) begin
      q_from_r[k+1] <= q_from_r[k];
      q_up_r[k+1]   <= q_up_r[k];
      q_len_r[k+1]  <= q_len_r[k];
      q_low_r[k+1]  <= {q_low_r[k][PB-2:0], 1'b0};
      q_quo_r[k+1]  <= {q_quo_r[k][PB-2:0], q_bit[k]};
      q_rem_r[k+1]  <= q_bit[k] ? LB'(q_trial[k] - {1'b0, q_len_r[k]})
                                : q_trial[k][LB-1:0];
    end
  end

  // falling direction rounds the step up so the value floors
  always_comb begin
    if (q_up_r[PB]) begin
      out_p = q_from_r[PB] + q_quo_r[PB];
    end else begin
      out_p = q_from_r[PB] - q_quo_r[PB] - PB'(q_rem_r[PB] != '0);
    end
  end

  assign out_vld = q_vld_r[PB];

endmodule

// File: src/trapezoid_pressure_profile.sv
// ----------------------------------------------------------------------------
// trapezoid_pressure_profile: periodic trapezoid setpoint generator
// Wraps a signed tick count into the breath cycle and returns the pressure
// setpoint with a configuration validity flag.
// ----------------------------------------------------------------------------
//
// channel  | handshake             | payload
// ---------+-----------------------+---------------------------------------
// input    | start & !busy         | in_sample_time
// result   | out_strobe (1 cycle)  | out_pressure_setpoint, out_profile_valid
// config   | cfg_valid & cfg_ready | cfg_index, cfg_data
//
// One word accepted per cycle; busy is high only in reset.
// An accepted word passes the front register, the queue, the one-bit-per-stage
// modulo stages, stages A and B, the ramp divide stages and the output register
// before out_strobe rises with its result.
// Reset (rst_n low, synchronous) empties the pipeline and loads register
// defaults. The receiver cannot stall; results stream out as they finish.
// ----------------------------------------------------------------------------
module trapezoid_pressure_profile (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [ttp_pkg::TIME_BITS-1:0] in_sample_time,
  output logic                                 out_strobe,
  output logic [ttp_pkg::PRESSURE_BITS-1:0]    out_pressure_setpoint,
  output logic                                 out_profile_valid,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ttp_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [ttp_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int PB = ttp_pkg::PRESSURE_BITS;

  ttp_pkg::cfg_t    cfg_r, cfg_nxt;
  ttp_pkg::q_stat_t q_stat;
  ttp_pkg::item_t   f_item, q_item;
  logic             f_vld;
  logic             accept;
  logic             b_vld;
  logic [PB-1:0]    b_p;
  logic             cfg_ok;

  logic          strobe_r;
  logic [PB-1:0] setpoint_r;
  logic          valid_r;

  // queue never fills: one push and one pop per cycle at most
  assign busy      = !rst_n || q_stat.full;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // register file
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        ttp_pkg::CFG_CYCLE_TIME:   cfg_nxt.cycle_time   =
                                     cfg_data[ttp_pkg::CYCLE_BITS-1:0];
        ttp_pkg::CFG_INHALE_RATIO: cfg_nxt.inhale_ratio =
                                     cfg_data[ttp_pkg::RATIO_FRAC_BITS-1:0];
        ttp_pkg::CFG_MIN_PRESSURE: cfg_nxt.min_pressure = cfg_data[PB-1:0];
        ttp_pkg::CFG_MAX_PRESSURE: cfg_nxt.max_pressure = cfg_data[PB-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cycle_time   <= ttp_pkg::CYCLE_BITS'(1000);
      cfg_r.inhale_ratio <= ttp_pkg::RATIO_FRAC_BITS'(1 << (ttp_pkg::RATIO_FRAC_BITS - 1));
      cfg_r.min_pressure <= PB'(500);
      cfg_r.max_pressure <= PB'(2000);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // config checks; the user must keep the registers static while words are in flight (not enforced here)
  assign cfg_ok = (cfg_r.cycle_time != '0) && (cfg_r.inhale_ratio != '0) &&
                  (cfg_r.min_pressure != '0) &&
                  (cfg_r.max_pressure > cfg_r.min_pressure);

  ttp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .sample_time (in_sample_time),
    .vld         (f_vld),
    .item        (f_item)
  );

  ttp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_vld),
    .push_item (f_item),
    .pop       (!q_stat.empty),
    .pop_item  (q_item),
    .stat      (q_stat)
  );

  ttp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (!q_stat.empty),
    .in_item (q_item),
    .cfg     (cfg_r),
    .out_vld (b_vld),
    .out_p   (b_p)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= b_vld;
    end
    setpoint_r <= b_p;
    valid_r    <= cfg_ok;
  end

  assign out_strobe            = strobe_r;
  assign out_pressure_setpoint = setpoint_r;
  assign out_profile_valid     = valid_r;

  // every accepted word yields a result strobe
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    $past(accept, ttp_pkg::LAT_CYCLES) && $past(rst_n, ttp_pkg::LAT_CYCLES) |-> out_strobe)
    else $error("accepted word produced no result");

  a_never_full: assert property (@(posedge clk) disable iff (!rst_n)
    !q_stat.full)
    else $error("front queue filled");

  a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_profile_valid |->
      (out_pressure_setpoint >= cfg_r.min_pressure) &&
      (out_pressure_setpoint <= cfg_r.max_pressure))
    else $error("setpoint outside configured range");

endmodule
